>>> hw/rtl/vrer_pkg.sv
package vrer_pkg;

  // default depth of the record memory in 64-bit words
  localparam int STORE_WORDS_DEF = 1024;

  localparam int SENDER_W = 16;
  localparam int ID_W     = 32;
  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 11;
  localparam int NEED_W   = 6;

  localparam logic [7:0]         LEN_MASK  = 8'hff;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_WORD   = 3'd1,
    ACT_POP    = 3'd2,
    ACT_CANCEL = 3'd3,
    ACT_FLUSH  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_DROPPED     = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_HEADER      = 3'd3,
    ST_CANCELLED   = 3'd4,
    ST_PAYLOAD     = 3'd5,
    ST_CANCEL_DONE = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ZERO,
    S_POP_HDR,
    S_POP_DATA,
    S_CAN_STEP,
    S_CAN_MOD
  } state_e;

  typedef struct packed {
    logic [2:0]          action;
    logic [SENDER_W-1:0] sender;
    logic [ID_W-1:0]     event_id;
    logic [WORD_W-1:0]   payload;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [SENDER_W-1:0] out_sender;
    logic [ID_W-1:0]     out_event_id;
    logic [WORD_W-1:0]   out_payload;
    logic                last;
    logic [COUNT_W-1:0]  cancel_count;
  } rsp_t;

  // header word plus one word per started group of eight payload bytes
  function automatic logic [NEED_W-1:0] words_for_len(input logic [7:0] len);
    logic [8:0] sum;
    sum = {1'b0, len & LEN_MASK} + 9'd7;
    return NEED_W'(1) + sum[8:3];
  endfunction

endpackage

>>> hw/rtl/vrer_store.sv
module vrer_store #(
  parameter int Words = vrer_pkg::STORE_WORDS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Words):0]   rd_addr_i,
  output logic [63:0]              rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Words)-1:0] wr_addr_i,
  input  logic [63:0]              wr_data_i
);
  localparam int AW = $clog2(Words);
  localparam logic [AW:0] WORDS_P = Words[AW:0];

  logic [63:0]   mem [Words];
  logic [63:0]   data_q;
  logic          oob_q;
  logic          rd_oob;
  logic [AW-1:0] rd_idx;

  // addresses past the end read as zero
  assign rd_oob = rd_addr_i >= WORDS_P;
  assign rd_idx = rd_oob ? '0 : rd_addr_i[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= mem[rd_idx];
      oob_q  <= rd_oob;
    end
  end

  assign rd_data_o = oob_q ? '0 : data_q;

endmodule

>>> hw/rtl/variable_record_event_ring.sv
// Ring of variable-length event records held in one 64-bit memory with one read and
// one write port (registered read). Each request is taken while idle and worked on
// in the next cycle, so a new request is taken only once the previous one is done;
// results go out through a single output register. Payload words and flushes end in
// the execute state; an accepted push writes its header there, then zero-fills the
// rest; a pop reads the header, then each payload word; a cancel reads each pending
// header and clears its sender on a match, plus a step at the wrap point. Output
// stalls add to these steps. The memory port is what paces pop and cancel.
module variable_record_event_ring #(
  parameter int StoreWords = vrer_pkg::STORE_WORDS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vrer_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vrer_pkg::rsp_t out_rsp_o
);
  import vrer_pkg::*;

  localparam int AW        = $clog2(StoreWords);
  localparam int GuardMaxI = 2 * StoreWords;
  localparam logic [AW:0]   SW_P      = StoreWords[AW:0];
  localparam logic [AW+1:0] SW_W      = StoreWords[AW+1:0];
  localparam logic [AW+1:0] GUARD_MAX = GuardMaxI[AW+1:0];

  state_e state_q, state_d;
  req_t   req_q;

  logic [AW-1:0]     wp_q, wp_d;
  logic [AW-1:0]     rp_q, rp_d;
  logic [AW:0]       we_q, we_d;
  logic [AW+1:0]     free_q, free_d;
  logic [NEED_W-1:0] wa_q, wa_d;
  logic              drop_q, drop_d;

  logic [AW-1:0]     fill_addr_q, fill_addr_d;
  logic [NEED_W-1:0] fill_left_q, fill_left_d;

  logic [AW-1:0]       pop_base_q, pop_base_d;
  logic [NEED_W-1:0]   pop_idx_q, pop_idx_d;
  logic [NEED_W-1:0]   pop_need_q, pop_need_d;
  logic [SENDER_W-1:0] pop_snd_q, pop_snd_d;
  logic [ID_W-1:0]     pop_id_q, pop_id_d;

  logic [AW+1:0]      can_r_q, can_r_d;
  logic [AW+1:0]      can_f_q, can_f_d;
  logic [AW:0]        can_we_q, can_we_d;
  logic [COUNT_W-1:0] can_cnt_q, can_cnt_d;
  logic [AW+1:0]      can_guard_q, can_guard_d;

  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;

  logic          rd_en;
  logic [AW:0]   rd_addr;
  logic [63:0]   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;

  logic emit_ok;
  logic in_take;

  // header fields of the word read last
  logic [SENDER_W-1:0] hdr_snd;
  logic [ID_W-1:0]     hdr_id;
  logic [NEED_W-1:0]   hdr_need;

  logic [NEED_W-1:0] push_need;
  logic [AW:0]       push_end;
  logic              push_over;
  logic [AW:0]       push_waste;
  logic              push_drop;

  logic          pop_empty;
  logic          pop_wrap;
  logic [AW-1:0] pop_rp;
  logic [AW+1:0] pe_rp;
  logic          pe_wrap;
  logic          pop_last;
  logic [AW:0]   pop_next_addr;

  logic can_live;
  logic can_at_end;

  vrer_store #(
    .Words(StoreWords)
  ) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign emit_ok    = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_take    = in_valid_i && in_ready_o;

  assign hdr_snd  = rd_data[15:0];
  assign hdr_id   = rd_data[47:16];
  assign hdr_need = words_for_len(hdr_id[7:0]);

  assign push_need  = words_for_len(req_q.event_id[7:0]);
  assign push_end   = {1'b0, wp_q} + {{(AW-NEED_W+1){1'b0}}, push_need};
  assign push_over  = push_end > SW_P;
  assign push_waste = push_over ? (SW_P - {1'b0, wp_q}) : '0;
  assign push_drop  = free_q < ({{(AW-NEED_W+2){1'b0}}, push_need} + {1'b0, push_waste});

  assign pop_empty = free_q >= SW_W;
  assign pop_wrap  = {1'b0, rp_q} >= we_q;
  assign pop_rp    = pop_wrap ? '0 : rp_q;
  assign pe_rp     = {2'b0, pop_base_q} + {{(AW-NEED_W+2){1'b0}}, hdr_need};
  assign pe_wrap   = pe_rp >= {1'b0, we_q};
  assign pop_last  = (pop_idx_q + NEED_W'(1)) == pop_need_q;
  assign pop_next_addr = {1'b0, pop_base_q}
                       + {{(AW-NEED_W+1){1'b0}}, pop_idx_q + NEED_W'(1)};

  assign can_live   = (can_f_q < SW_W) && (can_guard_q <= GUARD_MAX);
  assign can_at_end = can_r_q >= {1'b0, can_we_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_take) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (emit_ok) begin
          case (action_e'(req_q.action))
            ACT_PUSH:   state_d = (push_drop || push_need == NEED_W'(1)) ? S_IDLE : S_ZERO;
            ACT_POP:    state_d = pop_empty ? S_IDLE : S_POP_HDR;
            ACT_CANCEL: state_d = S_CAN_STEP;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ZERO: begin
        if (fill_left_q == NEED_W'(1)) state_d = S_IDLE;
      end
      S_POP_HDR: begin
        if (emit_ok) begin
          state_d = (hdr_snd == '0 || hdr_need == NEED_W'(1)) ? S_IDLE : S_POP_DATA;
        end
      end
      S_POP_DATA: begin
        if (emit_ok && pop_last) state_d = S_IDLE;
      end
      S_CAN_STEP: begin
        if (!can_live) begin
          if (emit_ok) state_d = S_IDLE;
        end else if (!can_at_end) begin
          state_d = S_CAN_MOD;
        end
      end
      S_CAN_MOD: state_d = S_CAN_STEP;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath, memory access and results
  always_comb begin
    logic          emit;
    rsp_t          rsp;
    logic [AW-1:0] start;
    logic [AW:0]   nxt;
    logic [AW:0]   wend;
    logic [AW+1:0] f1;

    emit  = 1'b0;
    rsp   = '0;
    start = '0;
    nxt   = '0;
    wend  = '0;
    f1    = '0;

    wp_d        = wp_q;
    rp_d        = rp_q;
    we_d        = we_q;
    free_d      = free_q;
    wa_d        = wa_q;
    drop_d      = drop_q;
    fill_addr_d = fill_addr_q;
    fill_left_d = fill_left_q;
    pop_base_d  = pop_base_q;
    pop_idx_d   = pop_idx_q;
    pop_need_d  = pop_need_q;
    pop_snd_d   = pop_snd_q;
    pop_id_d    = pop_id_q;
    can_r_d     = can_r_q;
    can_f_d     = can_f_q;
    can_we_d    = can_we_q;
    can_cnt_d   = can_cnt_q;
    can_guard_d = can_guard_q;

    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;

    rsp.last = 1'b1;

    case (state_q)
      S_EXEC: begin
        if (emit_ok) begin
          case (action_e'(req_q.action))
            ACT_PUSH: begin
              wa_d = push_need - NEED_W'(1);
              emit = 1'b1;
              if (push_drop) begin
                drop_d     = 1'b1;
                rsp.status = ST_DROPPED;
              end else begin
                drop_d = 1'b0;
                start  = wp_q;
                f1     = free_q;
                if (push_over) begin
                  // record would cross the end: mark the tail and restart at word 0
                  we_d  = {1'b0, wp_q};
                  f1    = free_q - {1'b0, push_waste};
                  start = '0;
                end
                free_d  = f1 - {{(AW-NEED_W+2){1'b0}}, push_need};
                nxt     = {1'b0, start} + {{(AW-NEED_W+1){1'b0}}, push_need};
                wp_d    = (nxt >= SW_P) ? '0 : nxt[AW-1:0];
                wr_en   = 1'b1;
                wr_addr = start;
                wr_data = {16'b0, req_q.event_id, req_q.sender};
                fill_addr_d = start + AW'(1);
                fill_left_d = push_need - NEED_W'(1);
                rsp.status  = ST_ACCEPTED;
              end
            end
            ACT_WORD: begin
              emit       = 1'b1;
              rsp.status = ST_DROPPED;
              if (wa_q != '0) begin
                if (!drop_q) begin
                  wend = (wp_q == '0) ? SW_P : {1'b0, wp_q};
                  if (wend >= {{(AW-NEED_W+1){1'b0}}, wa_q}) begin
                    nxt     = wend - {{(AW-NEED_W+1){1'b0}}, wa_q};
                    wr_en   = 1'b1;
                    wr_addr = nxt[AW-1:0];
                    wr_data = req_q.payload;
                  end
                  rsp.status = ST_ACCEPTED;
                end
                wa_d = wa_q - NEED_W'(1);
              end
            end
            ACT_POP: begin
              if (pop_empty) begin
                emit       = 1'b1;
                rsp.status = ST_EMPTY;
              end else begin
                if (pop_wrap) begin
                  free_d = free_q + (SW_W - {1'b0, we_q});
                  we_d   = SW_P;
                  rp_d   = '0;
                end
                rd_en      = 1'b1;
                rd_addr    = {1'b0, pop_rp};
                pop_base_d = pop_rp;
              end
            end
            ACT_CANCEL: begin
              can_r_d     = {2'b0, rp_q};
              can_f_d     = free_q;
              can_we_d    = we_q;
              can_cnt_d   = '0;
              can_guard_d = '0;
            end
            ACT_FLUSH: begin
              wp_d       = '0;
              rp_d       = '0;
              we_d       = SW_P;
              free_d     = SW_W;
              wa_d       = '0;
              drop_d     = 1'b0;
              emit       = 1'b1;
              rsp.status = ST_ACCEPTED;
            end
            default: ;
          endcase
        end
      end

      S_ZERO: begin
        // reserved payload words read as zero until they arrive
        wr_en       = 1'b1;
        wr_addr     = fill_addr_q;
        wr_data     = '0;
        fill_addr_d = fill_addr_q + AW'(1);
        fill_left_d = fill_left_q - NEED_W'(1);
      end

      S_POP_HDR: begin
        if (emit_ok) begin
          emit       = 1'b1;
          pop_snd_d  = hdr_snd;
          pop_id_d   = hdr_id;
          pop_need_d = hdr_need;
          pop_idx_d  = NEED_W'(1);
          rsp.out_event_id = hdr_id;
          if (hdr_snd == '0) begin
            rsp.status = ST_CANCELLED;
          end else begin
            rsp.status     = ST_HEADER;
            rsp.out_sender = hdr_snd;
            rsp.last       = (hdr_need == NEED_W'(1));
            if (hdr_need != NEED_W'(1)) begin
              rd_en   = 1'b1;
              rd_addr = {1'b0, pop_base_q} + {{AW{1'b0}}, 1'b1};
            end
          end
          // consume the record
          f1 = free_q + {{(AW-NEED_W+2){1'b0}}, hdr_need};
          if (pe_wrap) begin
            free_d = f1 + (SW_W - {1'b0, we_q});
            we_d   = SW_P;
            rp_d   = '0;
          end else begin
            free_d = f1;
            rp_d   = pe_rp[AW-1:0];
          end
        end
      end

      S_POP_DATA: begin
        if (emit_ok) begin
          emit             = 1'b1;
          rsp.status       = ST_PAYLOAD;
          rsp.out_sender   = pop_snd_q;
          rsp.out_event_id = pop_id_q;
          rsp.out_payload  = rd_data;
          rsp.last         = pop_last;
          if (!pop_last) begin
            rd_en     = 1'b1;
            rd_addr   = pop_next_addr;
            pop_idx_d = pop_idx_q + NEED_W'(1);
          end
        end
      end

      S_CAN_STEP: begin
        if (!can_live) begin
          if (emit_ok) begin
            emit             = 1'b1;
            rsp.status       = ST_CANCEL_DONE;
            rsp.cancel_count = can_cnt_q;
          end
        end else begin
          can_guard_d = can_guard_q + (AW+2)'(1);
          if (can_at_end) begin
            can_f_d  = can_f_q + (SW_W - {1'b0, can_we_q});
            can_r_d  = '0;
            can_we_d = SW_P;
          end else begin
            rd_en   = 1'b1;
            rd_addr = {1'b0, can_r_q[AW-1:0]};
          end
        end
      end

      S_CAN_MOD: begin
        if (req_q.sender != '0 && hdr_snd == req_q.sender) begin
          wr_en   = 1'b1;
          wr_addr = can_r_q[AW-1:0];
          wr_data = {rd_data[63:16], 16'b0};
          if (can_cnt_q != COUNT_MAX) can_cnt_d = can_cnt_q + COUNT_W'(1);
        end
        can_r_d = can_r_q + {{(AW-NEED_W+2){1'b0}}, hdr_need};
        can_f_d = can_f_q + {{(AW-NEED_W+2){1'b0}}, hdr_need};
      end

      default: ;
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      we_q        <= SW_P;
      free_q      <= SW_W;
      wa_q        <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      we_q        <= we_d;
      free_q      <= free_d;
      wa_q        <= wa_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) req_q <= in_req_i;
    fill_addr_q <= fill_addr_d;
    fill_left_q <= fill_left_d;
    pop_base_q  <= pop_base_d;
    pop_idx_q   <= pop_idx_d;
    pop_need_q  <= pop_need_d;
    pop_snd_q   <= pop_snd_d;
    pop_id_q    <= pop_id_d;
    can_r_q     <= can_r_d;
    can_f_q     <= can_f_d;
    can_we_q    <= can_we_d;
    can_cnt_q   <= can_cnt_d;
    can_guard_q <= can_guard_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import vrer_pkg::*;

  localparam int DEPTH        = STORE_WORDS_DEF;
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 190;
  localparam int HOLD_AFTER   = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 40;

  // action codes the block does not know
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  typedef struct {
    req_t req;
    bit   drain_first;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;

  always #5 clk = ~clk;

  variable_record_event_ring dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  pending_req_t request_q[$];
  rsp_t         ring_rsp_q[$];
  bit           drain_next = 1'b0;
  int           mismatch_cnt = 0;
  int           reqs_accepted = 0;
  bit           req_taken = 1'b0;

  // ring state as the predictor sees it
  logic [63:0] ring_mem [DEPTH];
  int          wr_ptr = 0;
  int          rd_ptr = 0;
  int          wrap_at = DEPTH;
  int          free_cnt = DEPTH;
  int          words_left = 0;
  bit          push_lost = 1'b0;

  function automatic int record_words(input logic [31:0] id);
    return 1 + ((int'(id[7:0]) + 7) >> 3);
  endfunction

  task automatic queue_rsp(input status_e st, input logic [15:0] snd, input logic [31:0] id,
                           input logic [63:0] pl, input logic lst, input logic [10:0] cnt);
    rsp_t r;
    r.status       = st;
    r.out_sender   = snd;
    r.out_event_id = id;
    r.out_payload  = pl;
    r.last         = lst;
    r.cancel_count = cnt;
    ring_rsp_q.push_back(r);
  endtask

  task automatic reader_catch_wrap();
    if (rd_ptr >= wrap_at) begin
      free_cnt += DEPTH - wrap_at;
      rd_ptr = 0;
      wrap_at = DEPTH;
    end
  endtask

  task automatic predict_ring(input req_t rq);
    int          need, waste, base, lim, r, f, we, cnt, guard;
    logic [63:0] hdr;
    logic [15:0] hs;
    logic [31:0] hid;
    status_e     st;
    case (rq.action)
      ACT_PUSH: begin
        need = record_words(rq.event_id);
        waste = 0;
        base = wr_ptr;
        if (base + need > DEPTH) waste = DEPTH - base;
        words_left = need - 1;
        // the wasted tail counts against free space
        if (free_cnt < need + waste) begin
          push_lost = 1'b1;
          queue_rsp(ST_DROPPED, '0, '0, '0, 1'b1, '0);
        end else begin
          push_lost = 1'b0;
          if (waste != 0) begin
            wrap_at = base;
            free_cnt -= waste;
            base = 0;
          end
          ring_mem[base] = {16'h0, rq.event_id, rq.sender};
          for (int i = 1; i < need; i++) ring_mem[base + i] = '0;
          free_cnt -= need;
          wr_ptr = base + need;
          if (wr_ptr >= DEPTH) wr_ptr = 0;
          queue_rsp(ST_ACCEPTED, '0, '0, '0, 1'b1, '0);
        end
      end
      ACT_WORD: begin
        st = ST_DROPPED;
        if (words_left != 0) begin
          if (!push_lost) begin
            lim = (wr_ptr == 0) ? DEPTH : wr_ptr;
            if (lim >= words_left) ring_mem[lim - words_left] = rq.payload;
            st = ST_ACCEPTED;
          end
          words_left--;
        end
        queue_rsp(st, '0, '0, '0, 1'b1, '0);
      end
      ACT_POP: begin
        if (free_cnt >= DEPTH) begin
          queue_rsp(ST_EMPTY, '0, '0, '0, 1'b1, '0);
        end else begin
          reader_catch_wrap();
          hdr = ring_mem[rd_ptr];
          hs = hdr[15:0];
          hid = hdr[47:16];
          need = record_words(hid);
          if (hs == '0) begin
            queue_rsp(ST_CANCELLED, '0, hid, '0, 1'b1, '0);
          end else begin
            queue_rsp(ST_HEADER, hs, hid, '0, need == 1, '0);
            for (int i = 1; i < need; i++)
              queue_rsp(ST_PAYLOAD, hs, hid, ring_mem[rd_ptr + i], i + 1 == need, '0);
          end
          rd_ptr += need;
          free_cnt += need;
          reader_catch_wrap();
        end
      end
      ACT_CANCEL: begin
        r = rd_ptr;
        f = free_cnt;
        we = wrap_at;
        cnt = 0;
        guard = 0;
        while (f < DEPTH && guard <= 2 * DEPTH) begin
          guard++;
          if (r >= we) begin
            f += DEPTH - we;
            r = 0;
            we = DEPTH;
          end else begin
            hdr = ring_mem[r];
            need = record_words(hdr[47:16]);
            if (rq.sender != '0 && hdr[15:0] == rq.sender) begin
              ring_mem[r] = {hdr[63:16], 16'h0};
              if (cnt < 2047) cnt++;
            end
            r += need;
            f += need;
          end
        end
        queue_rsp(ST_CANCEL_DONE, '0, '0, '0, 1'b1, cnt[10:0]);
      end
      ACT_FLUSH: begin
        wr_ptr = 0;
        rd_ptr = 0;
        wrap_at = DEPTH;
        free_cnt = DEPTH;
        words_left = 0;
        push_lost = 1'b0;
        queue_rsp(ST_ACCEPTED, '0, '0, '0, 1'b1, '0);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_rsp(input rsp_t got);
    rsp_t want;
    if (ring_rsp_q.size() == 0) begin
      report_mismatch("status of a result with nothing pending", 64'(got.status), '0);
    end else begin
      want = ring_rsp_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.out_sender !== want.out_sender)
        report_mismatch("sender", 64'(got.out_sender), 64'(want.out_sender));
      if (got.out_event_id !== want.out_event_id)
        report_mismatch("event id", 64'(got.out_event_id), 64'(want.out_event_id));
      if (got.out_payload !== want.out_payload)
        report_mismatch("payload", got.out_payload, want.out_payload);
      if (got.last !== want.last)
        report_mismatch("last", 64'(got.last), 64'(want.last));
      if (got.cancel_count !== want.cancel_count)
        report_mismatch("cancel count", 64'(got.cancel_count), 64'(want.cancel_count));
    end
  endtask

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_sender();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(1, 4));
    if (r < 70) return 16'h0000;
    if (r < 78) return 16'hffff;
    return 16'($urandom());
  endfunction

  function automatic logic [31:0] pick_event_id();
    logic [31:0] id;
    int          r;
    id = $urandom();
    r = $urandom_range(0, 99);
    if (r < 45) id[7:0] = 8'($urandom_range(0, 16));
    else if (r < 75) id[7:0] = 8'($urandom_range(17, 64));
    else if (r < 95) id[7:0] = 8'($urandom_range(65, 255));
    else id[7:0] = r[0] ? 8'hff : 8'h00;
    return id;
  endfunction

  function automatic logic [63:0] pick_payload();
    return {32'($urandom()), 32'($urandom())};
  endfunction

  task automatic add_request(input logic [2:0] act, input logic [15:0] snd,
                             input logic [31:0] id, input logic [63:0] pl);
    pending_req_t p;
    p.req.action   = act;
    p.req.sender   = snd;
    p.req.event_id = id;
    p.req.payload  = pl;
    p.drain_first  = drain_next;
    drain_next = 1'b0;
    request_q.push_back(p);
  endtask

  task automatic add_push_run(input logic [15:0] snd, input logic [31:0] id, input int nwords);
    add_request(ACT_PUSH, snd, id, pick_payload());
    for (int i = 0; i < nwords; i++)
      add_request(ACT_WORD, pick_sender(), pick_event_id(), pick_payload());
  endtask

  // request side
  int in_gap = 0;
  int in_calm = 0;

  always @(negedge clk) begin : drive_requests
    logic nxt_valid;
    req_t nxt_req;
    nxt_valid = in_valid;
    nxt_req = in_req;
    if (req_taken) nxt_valid = 1'b0;
    if (rst_n && !nxt_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].drain_first && ring_rsp_q.size() != 0)) begin
        nxt_req = request_q[0].req;
        void'(request_q.pop_front());
        nxt_valid = 1'b1;
        in_gap = pick_gap(in_calm);
      end
    end
    in_valid <= nxt_valid;
    in_req <= nxt_req;
  end

  // result side, with one long hold-off so the block backs up
  int out_stall = 0;
  int out_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin : drive_ready
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (!hold_done && reqs_accepted >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      nxt_ready = 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall = pick_gap(out_calm);
    end
    out_ready <= nxt_ready;
  end

  always @(posedge clk) begin : watch_ports
    req_taken = rst_n && in_valid && in_ready;
    if (req_taken) begin
      predict_ring(in_req);
      reqs_accepted++;
    end
    if (rst_n && out_valid && out_ready) check_rsp(out_rsp);
  end

  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : stimulus
    int          made, switch_at, pick, nwords, full;
    bit          filling, paused_mid;
    logic [15:0] snd;
    logic [31:0] id;

    for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;

    // directed part
    add_request(ACT_POP, 16'h0000, 32'h0, 64'h0);              // empty ring
    add_request(ACT_WORD, 16'hffff, '1, '1);                   // word with nothing awaited
    add_request(ACT_CANCEL, 16'h0000, 32'h0, 64'h0);           // cancel of no sender
    add_request(ACT_PUSH, 16'hffff, 32'hffff_ff00, 64'h0);     // header only record
    add_request(ACT_PUSH, 16'h0001, 32'h0000_00ff, '1);        // longest record
    add_request(ACT_WORD, 16'h0000, 32'h0, '1);
    add_request(ACT_WORD, 16'h0000, 32'h0, 64'h0);             // rest left abandoned
    add_request(ACT_PUSH, 16'h0000, 32'h8000_0008, 64'h0);     // no sender
    add_request(ACT_WORD, 16'h0000, 32'h0, 64'h0123_4567_89ab_cdef);
    add_request(ACT_PUSH, 16'h0002, 32'h5a5a_a509, 64'h0);
    add_request(ACT_WORD, 16'h0000, 32'h0, 64'hfedc_ba98_7654_3210);
    add_request(ACT_WORD, 16'h0000, 32'h0, 64'h8000_0000_0000_0001);
    add_request(ACT_CANCEL, 16'h0002, 32'h0, 64'h0);
    for (int i = 0; i < 4; i++) add_request(ACT_POP, 16'h0000, 32'h0, 64'h0);
    // pop while the push is still taking words
    add_request(ACT_PUSH, 16'h0003, 32'h0000_0118, 64'h0);
    add_request(ACT_WORD, 16'h0000, 32'h0, 64'h1111_2222_3333_4444);
    add_request(ACT_POP, 16'h0000, 32'h0, 64'h0);
    add_request(ACT_WORD, 16'h0000, 32'h0, 64'h5555_6666_7777_8888);
    add_request(ACT_WORD, 16'h0000, 32'h0, 64'h9999_aaaa_bbbb_cccc);
    // flush in the middle of a push
    add_request(ACT_PUSH, 16'h0004, 32'h0000_0210, 64'h0);
    add_request(ACT_WORD, 16'h0000, 32'h0, 64'hdddd_eeee_ffff_0000);
    add_request(ACT_FLUSH, 16'h0000, 32'h0, 64'h0);
    add_request(ACT_WORD, 16'h0000, 32'h0, 64'h0f0f_0f0f_0f0f_0f0f);
    add_request(ACT_SPARE_HI, 16'h0000, 32'h0, 64'h0);

    // random part: fill phases lean on long records so the ring runs full and wraps
    drain_next = 1'b1;
    made = 0;
    filling = 1'b1;
    switch_at = 80;
    paused_mid = 1'b0;
    while (made < RANDOM_ITEMS) begin
      if (made >= RANDOM_ITEMS / 2 && !paused_mid) begin
        drain_next = 1'b1;
        paused_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 80 : 30)) begin
        snd = pick_sender();
        id = pick_event_id();
        if (filling && $urandom_range(0, 3) != 0) begin
          id[7:0] = 8'($urandom_range(160, 255));
          nwords = $urandom_range(0, 1);
        end else begin
          full = record_words(id) - 1;
          nwords = ($urandom_range(0, 9) < 7) ? full : $urandom_range(0, full);
        end
        add_push_run(snd, id, nwords);
        made += 1 + nwords;
      end else if (pick < (filling ? 88 : 78)) begin
        add_request(ACT_POP, pick_sender(), pick_event_id(), pick_payload());
        made++;
      end else if (pick < 93) begin
        add_request(ACT_CANCEL, pick_sender(), pick_event_id(), pick_payload());
        made++;
      end else if (pick < 96) begin
        add_request(ACT_WORD, pick_sender(), pick_event_id(), pick_payload());
        made++;
      end else if (pick < 98 && !filling) begin
        add_request(ACT_FLUSH, pick_sender(), pick_event_id(), pick_payload());
        made++;
      end else begin
        add_request(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), pick_sender(),
                    pick_event_id(), pick_payload());
      end
      if (made >= switch_at) begin
        filling = !filling;
        switch_at = made + (filling ? 80 : 25);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (request_q.size() != 0 || in_valid || ring_rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
